/* rtl/xvtp_pkg.sv */
// shared types and codes for the xml-rpc value token parser
package xvtp_pkg;

  localparam int TEXT_REF_BITS = 16;

  typedef logic [TEXT_REF_BITS-1:0] text_ref_t;
  typedef logic [2:0] kind_t;
  typedef logic [3:0] tag_t;

  // node kinds
  localparam kind_t K_START   = 3'd0;
  localparam kind_t K_END     = 3'd1;
  localparam kind_t K_CHARS   = 3'd2;
  localparam kind_t K_OTHER   = 3'd3;
  localparam kind_t K_RESTART = 3'd4;

  // tag codes
  localparam tag_t T_VALUE  = 4'd0;
  localparam tag_t T_STRUCT = 4'd1;
  localparam tag_t T_ARRAY  = 4'd2;
  localparam tag_t T_MEMBER = 4'd3;
  localparam tag_t T_NAME   = 4'd4;
  localparam tag_t T_DATA   = 4'd5;
  localparam tag_t T_PARAM  = 4'd6;
  localparam tag_t T_FAULT  = 4'd7;

  typedef enum logic [3:0] {
    A_NONE    = 4'd0,
    A_BEGIN   = 4'd1,
    A_SET     = 4'd2,
    A_EMPTY   = 4'd3,
    A_MEMBER  = 4'd4,
    A_ELEM    = 4'd5,
    A_LEAVE   = 4'd6,
    A_SIBLING = 4'd7,
    A_DONE    = 4'd8,
    A_ERROR   = 4'd9
  } action_t;

  typedef enum logic [15:0] {
    S_PARAM  = 16'h0001,
    S_VBEGIN = 16'h0002,
    S_VEND   = 16'h0004,
    S_SBEGIN = 16'h0008,
    S_SEND   = 16'h0010,
    S_MBEGIN = 16'h0020,
    S_NBEGIN = 16'h0040,
    S_NAME   = 16'h0080,
    S_NEND   = 16'h0100,
    S_CBEGIN = 16'h0200,
    S_SCALAR = 16'h0400,
    S_CEND   = 16'h0800,
    S_ABEGIN = 16'h1000,
    S_DBEGIN = 16'h2000,
    S_DEND   = 16'h4000,
    S_AEND   = 16'h8000
  } state_t;

  typedef struct packed {
    kind_t     node_kind;
    tag_t      tag_code;
    text_ref_t text_ref;
  } token_t;

  typedef struct packed {
    action_t   action;
    text_ref_t value_ref;
    logic      value_present;
    tag_t      type_code;
  } result_t;

endpackage

/* rtl/xvtp_in_reg.sv */
// input register holding one token word
module xvtp_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  xvtp_pkg::token_t in_tok,
  input  logic            take,
  output logic            tok_valid,
  output xvtp_pkg::token_t tok
);
  import xvtp_pkg::*;

  logic   valid_r;
  token_t tok_r;

  // refill in the same cycle the held word moves on
  assign in_ready  = !valid_r || take;
  assign tok_valid = valid_r;
  assign tok       = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= in_tok;
    end
  end

endmodule

/* rtl/xvtp_grammar.sv */
// grammar state and per-token transition logic
module xvtp_grammar (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  xvtp_pkg::token_t tok,
  output xvtp_pkg::result_t res
);
  import xvtp_pkg::*;

  state_t    state_r, state_nxt;
  text_ref_t pend_text_r, pend_text_nxt;
  logic      pend_valid_r, pend_valid_nxt;
  tag_t      last_type_r, last_type_nxt;
  logic      err_r, err_nxt;

  kind_t     kind;
  tag_t      tag;
  logic      st, en, ch, rs;
  action_t   act;
  text_ref_t vref;
  logic      vpres;
  tag_t      tcode;

  always_comb begin
    // unused kind codes act as other node
    kind = (tok.node_kind > K_RESTART) ? K_OTHER : tok.node_kind;
    tag  = tok.tag_code;
    st   = (kind == K_START);
    en   = (kind == K_END);
    ch   = (kind == K_CHARS);
    rs   = (kind == K_RESTART);
  end

  always_comb begin
    act            = A_NONE;
    state_nxt      = state_r;
    vref           = '0;
    vpres          = 1'b0;
    tcode          = '0;
    pend_text_nxt  = pend_text_r;
    pend_valid_nxt = pend_valid_r;
    last_type_nxt  = last_type_r;
    err_nxt        = err_r;

    if (rs) begin
      err_nxt   = 1'b0;
      state_nxt = S_PARAM;
      act       = A_BEGIN;
    end else if (!err_r) begin
      unique case (state_r)
        S_PARAM, S_NEND: begin
          if (st) begin
            if (tag == T_VALUE) state_nxt = S_VBEGIN;
            else act = A_ERROR;
          end else if (en) begin
            act = A_ERROR;
          end
        end
        S_VBEGIN: begin
          if (st) begin
            if (tag == T_STRUCT) state_nxt = S_SBEGIN;
            else if (tag == T_ARRAY) state_nxt = S_ABEGIN;
            else if (tag[3]) state_nxt = S_CBEGIN;
            else act = A_ERROR;
            if (act != A_ERROR) begin
              pend_valid_nxt = 1'b0;
              pend_text_nxt  = '0;
              last_type_nxt  = tag;
            end
          end else if (ch) begin
            pend_text_nxt  = tok.text_ref;
            pend_valid_nxt = 1'b1;
          end else if (en && tag == T_VALUE) begin
            // untyped value: bare text or empty
            act            = A_SET;
            vref           = pend_valid_r ? pend_text_r : '0;
            vpres          = pend_valid_r;
            pend_text_nxt  = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = S_VEND;
          end else begin
            act = A_ERROR;
          end
        end
        S_VEND: begin
          if (en) begin
            if (tag == T_MEMBER) begin
              act       = A_LEAVE;
              state_nxt = S_SBEGIN;
            end else if (tag == T_DATA) begin
              act       = A_LEAVE;
              state_nxt = S_DEND;
            end else if (tag == T_PARAM || tag == T_FAULT) begin
              act = A_DONE;
            end else begin
              act = A_ERROR;
            end
          end else if (st) begin
            if (tag == T_VALUE) begin
              act       = A_SIBLING;
              tcode     = last_type_r;
              state_nxt = S_VBEGIN;
            end else begin
              act = A_ERROR;
            end
          end
        end
        S_SBEGIN: begin
          if (st) begin
            if (tag == T_MEMBER) state_nxt = S_MBEGIN;
            else act = A_ERROR;
          end else if (en) begin
            if (tag == T_STRUCT) state_nxt = S_SEND;
            else act = A_ERROR;
          end
        end
        S_SEND, S_CEND, S_AEND: begin
          if (en) begin
            if (tag == T_VALUE) state_nxt = S_VEND;
            else act = A_ERROR;
          end else if (st) begin
            act = A_ERROR;
          end
        end
        S_MBEGIN: begin
          if (st) begin
            if (tag == T_NAME) state_nxt = S_NBEGIN;
            else act = A_ERROR;
          end else if (en) begin
            act = A_ERROR;
          end
        end
        S_NBEGIN: begin
          if (ch) begin
            act       = A_MEMBER;
            vref      = tok.text_ref;
            vpres     = 1'b1;
            state_nxt = S_NAME;
          end else begin
            act = A_ERROR;
          end
        end
        S_NAME: begin
          if (en) begin
            if (tag == T_NAME) state_nxt = S_NEND;
            else act = A_ERROR;
          end else if (st) begin
            act = A_ERROR;
          end
        end
        S_CBEGIN: begin
          if (ch) begin
            act       = A_SET;
            vref      = tok.text_ref;
            vpres     = 1'b1;
            state_nxt = S_SCALAR;
          end else if (en && tag == last_type_r) begin
            act       = A_EMPTY;
            state_nxt = S_CEND;
          end else begin
            act = A_ERROR;
          end
        end
        S_SCALAR: begin
          if (en) begin
            if (tag == last_type_r) state_nxt = S_CEND;
            else act = A_ERROR;
          end else if (st) begin
            act = A_ERROR;
          end
        end
        S_ABEGIN: begin
          if (st) begin
            if (tag == T_DATA) state_nxt = S_DBEGIN;
            else act = A_ERROR;
          end else if (en) begin
            act = A_ERROR;
          end
        end
        S_DBEGIN: begin
          if (st) begin
            if (tag == T_VALUE) begin
              act       = A_ELEM;
              state_nxt = S_VBEGIN;
            end else begin
              act = A_ERROR;
            end
          end else if (en) begin
            if (tag == T_DATA) state_nxt = S_DEND;
            else act = A_ERROR;
          end
        end
        S_DEND: begin
          if (en) begin
            if (tag == T_ARRAY) state_nxt = S_AEND;
            else act = A_ERROR;
          end else if (st) begin
            act = A_ERROR;
          end
        end
        default: begin
          state_nxt = S_PARAM;
        end
      endcase

      // grammar violation: hold state, drop payload, go sticky
      if (act == A_ERROR) begin
        err_nxt        = 1'b1;
        state_nxt      = state_r;
        vref           = '0;
        vpres          = 1'b0;
        tcode          = '0;
        pend_text_nxt  = pend_text_r;
        pend_valid_nxt = pend_valid_r;
        last_type_nxt  = last_type_r;
      end
    end
  end

  assign res.action        = act;
  assign res.value_ref     = vref;
  assign res.value_present = vpres;
  assign res.type_code     = tcode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_PARAM;
      pend_text_r  <= '0;
      pend_valid_r <= 1'b0;
      last_type_r  <= '0;
      err_r        <= 1'b0;
    end else if (step) begin
      state_r      <= state_nxt;
      pend_text_r  <= pend_text_nxt;
      pend_valid_r <= pend_valid_nxt;
      last_type_r  <= last_type_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

/* rtl/xvtp_out_reg.sv */
// result register toward the downstream channel
module xvtp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  xvtp_pkg::result_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output xvtp_pkg::result_t out_res
);
  import xvtp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/xmlrpc_value_token_parser.sv */
// top level: xml-rpc value token parser, one action word per token word
// path: input reg holds the token word, then the result reg holds its action word
// throughput: one token word per cycle while the result reg has room, set by the single
// grammar transition step between the input register and the result register
// reset: synchronous active-low rst_n empties both registers, returns the
// grammar to expect-param-value and clears pending text, last type and error
module xmlrpc_value_token_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_node_kind,
  input  logic [3:0]           in_tag_code,
  input  xvtp_pkg::text_ref_t  in_text_ref,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_action,
  output xvtp_pkg::text_ref_t  out_value_ref,
  output logic                 out_value_present,
  output logic [3:0]           out_type_code
);
  import xvtp_pkg::*;

  token_t  in_tok, tok;
  logic    tok_valid, room, advance;
  result_t res, out_res;

  assign in_tok.node_kind = in_node_kind;
  assign in_tok.tag_code  = in_tag_code;
  assign in_tok.text_ref  = in_text_ref;

  // a held word moves into the result register when there is room
  assign advance = tok_valid && room;

  xvtp_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_tok    (in_tok),
    .take      (advance),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  xvtp_grammar u_gram (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .tok   (tok),
    .res   (res)
  );

  xvtp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_action        = out_res.action;
  assign out_value_ref     = out_res.value_ref;
  assign out_value_present = out_res.value_present;
  assign out_type_code     = out_res.type_code;

endmodule
